// ===== rtl/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// shared types and constants of the timed tour fitness evaluator
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned ROW_W  = 6;
  localparam int unsigned TIME_W = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // infeasibility penalty: min(gen / 10, 10) * 750 + 500
  localparam int unsigned PEN_STEP      = 750;
  localparam int unsigned PEN_BASE      = 500;
  localparam int unsigned PEN_MAX_STEPS = 10;
  // gen / 10 as (gen * 205) >> 11, exact for all 10-bit gen
  localparam int unsigned PEN_RECIP     = 205;
  localparam int unsigned PEN_SHIFT     = 11;

  typedef enum logic [1:0] {
    REQ_TRAVEL = 2'd0,
    REQ_PREF   = 2'd1,
    REQ_NODE   = 2'd2,
    REQ_TOUR   = 2'd3
  } req_e;

  typedef enum logic {
    REG_BUDGET = 1'b0,
    REG_GEN    = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP1,
    S_STEP2,
    S_RET,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [15:0] pref;
    logic [15:0] travel;
  } mat_word_t;

  typedef struct packed {
    logic [15:0] service;
    logic [15:0] open;
    logic [15:0] close;
    logic [15:0] score;
  } node_rec_t;

  typedef struct packed {
    logic travel_we;
    logic pref_we;
    logic node_we;
    logic rd_en;
  } store_ctl_t;

endpackage

// ===== rtl/tte_store.sv =====
// ----------------------------------------------------------------------------
// tte_store
// pair matrix (travel time, preference) and per-node record memories
// ----------------------------------------------------------------------------
module tte_store import tte_pkg::*; #(
  parameter int unsigned NODES = 64
) (
  input  logic                                clk_i,
  input  store_ctl_t                          ctl_i,
  input  logic [$clog2(NODES*NODES)-1:0]      wr_mat_addr_i,
  input  logic [$clog2(NODES)-1:0]            wr_node_addr_i,
  input  logic [15:0]                         wr_travel_i,
  input  logic [15:0]                         wr_pref_i,
  input  node_rec_t                           wr_node_i,
  input  logic [$clog2(NODES*NODES)-1:0]      rd_mat_addr_i,
  input  logic [$clog2(NODES)-1:0]            rd_node_addr_i,
  output mat_word_t                           rd_mat_o,
  output node_rec_t                           rd_node_o
);

  localparam int unsigned MAT_DEPTH = NODES * NODES;

  mat_word_t mat_mem [MAT_DEPTH];
  node_rec_t node_mem [NODES];

  mat_word_t mat_rd_q;
  node_rec_t node_rd_q;

  // halves of the matrix word are written separately
  always_ff @(posedge clk_i) begin
    if (ctl_i.travel_we) begin
      mat_mem[wr_mat_addr_i].travel <= wr_travel_i;
    end
    if (ctl_i.pref_we) begin
      mat_mem[wr_mat_addr_i].pref <= wr_pref_i;
    end
    if (ctl_i.rd_en) begin
      mat_rd_q <= mat_mem[rd_mat_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.node_we) begin
      node_mem[wr_node_addr_i] <= wr_node_i;
    end
    if (ctl_i.rd_en) begin
      node_rd_q <= node_mem[rd_node_addr_i];
    end
  end

  assign rd_mat_o  = mat_rd_q;
  assign rd_node_o = node_rd_q;

endmodule

// ===== rtl/timed_tour_fitness_evaluator.sv =====
// ----------------------------------------------------------------------------
// timed_tour_fitness_evaluator
// scores a tour of an orienteering problem with time windows
// ----------------------------------------------------------------------------
// words are issued with start while busy is low; req_type selects the kind.
// load words (travel time, preference, node record) are written into the
// memories at the accept edge, busy never rises for them. a tour word raises
// busy: S_STEP1 takes the pair matrix and node record read at the accept
// edge and waits for the window to open, S_STEP2 checks its close and the
// budget and updates the value. a last word also runs the depot step (S_RET,
// S_STEP1, S_STEP2) and S_DONE, which forms the fitness, before a new word
// is accepted. each step is bounded by the memory read latency plus the
// current node and elapsed time update, which the next step needs for its
// address and arrival. the result shows on fitness_o and feasible_o for one
// cycle with done_o, in the cycle busy falls; the receiver cannot stall it.
// time_budget and generation are written on the apb port at 0x0 and 0x4;
// the user must write them only while no tour is in progress; the block
// does not enforce it. reset returns the tour to the depot with zero time
// and value; the memories are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
module timed_tour_fitness_evaluator import tte_pkg::*; #(
  parameter int unsigned NODES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic [ROW_W-1:0]   col_i,
  input  logic [15:0]        time_value_i,
  input  logic [15:0]        window_open_i,
  input  logic [15:0]        window_close_i,
  input  logic signed [15:0] score_i,
  input  logic               last_i,
  output logic               done_o,
  output logic signed [31:0] fitness_o,
  output logic               feasible_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW  = $clog2(NODES * NODES);
  localparam int unsigned NAW = $clog2(NODES);

  // configuration
  logic [TIME_W-1:0] budget_q;
  logic [9:0]        gen_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      gen_q    <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        REG_BUDGET: budget_q <= pwdata[TIME_W-1:0];
        REG_GEN:    gen_q    <= pwdata[9:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_BUDGET: prdata = {8'd0, budget_q};
      REG_GEN:    prdata = {22'd0, gen_q};
      default:    prdata = '0;
    endcase
  end

  // control state
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  cur_q, cur_d;
  logic [ROW_W-1:0]  nxt_q, nxt_d;
  logic              nxt_ok_q, nxt_ok_d;
  logic              last_q, last_d;
  logic              ret_q, ret_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic signed [31:0] val_q, val_d;
  logic              feas_q, feas_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic              done_q, done_d;
  logic signed [31:0] fit_q, fit_d;
  logic              ok_q, ok_d;

  logic accept;
  logic tour_acc;
  logic row_ok;
  logic col_ok;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign tour_acc = accept && (req_e'(req_type_i) == REQ_TOUR);
  assign row_ok   = (32'(row_i) < 32'(NODES));
  assign col_ok   = (32'(col_i) < 32'(NODES));

  // memory ports
  store_ctl_t ctl;
  logic [31:0] wr_lin;
  logic [31:0] wr_node_lin;
  logic [ROW_W-1:0] rd_next;
  logic        rd_ok;
  logic [31:0] rd_lin;
  logic [31:0] rd_node_lin;
  mat_word_t   mat_rd;
  node_rec_t   node_rd;
  node_rec_t   wr_node;

  assign wr_lin      = 32'(row_i) * 32'(NODES) + 32'(col_i);
  assign wr_node_lin = 32'(row_i);
  assign rd_next     = (state_q == S_RET) ? '0 : row_i;
  assign rd_ok       = (state_q == S_RET) || row_ok;
  assign rd_lin      = rd_ok ? (32'(cur_q) * 32'(NODES) + 32'(rd_next)) : '0;
  assign rd_node_lin = rd_ok ? 32'(rd_next) : '0;

  assign wr_node.service = time_value_i;
  assign wr_node.open    = window_open_i;
  assign wr_node.close   = window_close_i;
  assign wr_node.score   = score_i;

  always_comb begin
    ctl           = '0;
    ctl.travel_we = accept && (req_e'(req_type_i) == REQ_TRAVEL) && row_ok && col_ok;
    ctl.pref_we   = accept && (req_e'(req_type_i) == REQ_PREF) && row_ok && col_ok;
    ctl.node_we   = accept && (req_e'(req_type_i) == REQ_NODE) && row_ok;
    ctl.rd_en     = tour_acc || (state_q == S_RET);
  end

  tte_store #(
    .NODES (NODES)
  ) u_store (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .wr_mat_addr_i  (wr_lin[AW-1:0]),
    .wr_node_addr_i (wr_node_lin[NAW-1:0]),
    .wr_travel_i    (time_value_i),
    .wr_pref_i      (score_i),
    .wr_node_i      (wr_node),
    .rd_mat_addr_i  (rd_lin[AW-1:0]),
    .rd_node_addr_i (rd_node_lin[NAW-1:0]),
    .rd_mat_o       (mat_rd),
    .rd_node_o      (node_rd)
  );

  // first half of a step: arrive and wait for the window to open
  logic [TIME_W:0]   arr_sum;
  logic [TIME_W-1:0] arr_sat;
  logic [TIME_W-1:0] open_ext;

  assign arr_sum  = {1'b0, elapsed_q} + (TIME_W+1)'(mat_rd.travel);
  assign arr_sat  = arr_sum[TIME_W] ? TIME_MAX : arr_sum[TIME_W-1:0];
  assign open_ext = TIME_W'(node_rd.open);

  // second half: window close, value and budget
  logic [TIME_W:0]    fin_sum;
  logic               late;
  logic [TIME_W-1:0]  fin_sat;
  logic signed [33:0] v_sum;
  logic signed [31:0] v_sat;

  assign fin_sum = {1'b0, t_q} + (TIME_W+1)'(node_rd.service);
  assign late    = fin_sum > (TIME_W+1)'(node_rd.close);
  assign fin_sat = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  assign v_sum   = 34'(val_q) + 34'($signed(node_rd.score)) + 34'($signed(mat_rd.pref));

  always_comb begin
    if (v_sum > 34'sd2147483647) begin
      v_sat = 32'sh7fffffff;
    end else if (v_sum < -34'sd2147483648) begin
      v_sat = 32'sh80000000;
    end else begin
      v_sat = v_sum[31:0];
    end
  end

  // penalty and final fitness
  logic [20:0]        gen_prod;
  logic [9:0]         gen_div;
  logic [3:0]         pen_steps;
  logic [13:0]        penalty;
  logic signed [32:0] f_sum;
  logic signed [31:0] f_sat;

  assign gen_prod  = 21'(gen_q) * 21'(PEN_RECIP);
  assign gen_div   = gen_prod[PEN_SHIFT +: 10];
  assign pen_steps = (gen_div > 10'(PEN_MAX_STEPS)) ? 4'(PEN_MAX_STEPS) : gen_div[3:0];
  assign penalty   = 14'(pen_steps) * 14'(PEN_STEP) + 14'(PEN_BASE);
  assign f_sum     = 33'(val_q) - 33'(penalty);

  always_comb begin
    if (feas_q) begin
      f_sat = val_q;
    end else if (f_sum < -33'sd2147483648) begin
      f_sat = 32'sh80000000;
    end else begin
      f_sat = f_sum[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    nxt_ok_d  = nxt_ok_q;
    last_d    = last_q;
    ret_d     = ret_q;
    elapsed_d = elapsed_q;
    val_d     = val_q;
    feas_d    = feas_q;
    t_d       = t_q;
    done_d    = 1'b0;
    fit_d     = fit_q;
    ok_d      = ok_q;
    unique case (state_q)
      S_IDLE: begin
        if (tour_acc) begin
          nxt_d    = row_i;
          nxt_ok_d = row_ok;
          last_d   = last_i;
          state_d  = S_STEP1;
        end
      end
      S_STEP1: begin
        t_d     = (arr_sat < open_ext) ? open_ext : arr_sat;
        state_d = S_STEP2;
      end
      S_STEP2: begin
        if (feas_q) begin
          if (!nxt_ok_q) begin
            feas_d = 1'b0;
          end else if (late) begin
            elapsed_d = t_q;
            feas_d    = 1'b0;
          end else begin
            val_d     = v_sat;
            elapsed_d = fin_sat;
            cur_d     = nxt_q;
            feas_d    = !(fin_sat > budget_q);
          end
        end
        if (last_q && !ret_q) begin
          state_d = S_RET;
        end else if (last_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RET: begin
        nxt_d    = '0;
        nxt_ok_d = 1'b1;
        ret_d    = 1'b1;
        state_d  = S_STEP1;
      end
      S_DONE: begin
        done_d    = 1'b1;
        fit_d     = f_sat;
        ok_d      = feas_q;
        cur_d     = '0;
        elapsed_d = '0;
        val_d     = '0;
        feas_d    = 1'b1;
        ret_d     = 1'b0;
        last_d    = 1'b0;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      nxt_ok_q  <= 1'b0;
      last_q    <= 1'b0;
      ret_q     <= 1'b0;
      elapsed_q <= '0;
      val_q     <= '0;
      feas_q    <= 1'b1;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      nxt_ok_q  <= nxt_ok_d;
      last_q    <= last_d;
      ret_q     <= ret_d;
      elapsed_q <= elapsed_d;
      val_q     <= val_d;
      feas_q    <= feas_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d;
    t_q   <= t_d;
    fit_q <= fit_d;
    ok_q  <= ok_d;
  end

  assign done_o     = done_q;
  assign fitness_o  = fit_q;
  assign feasible_o = ok_q;

  // the result only leaves after the block has gone back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a tour is still in progress");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> done_q)
    else $error("final state did not produce a result");

  a_ret_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RET) |-> (last_q && !ret_q))
    else $error("depot return step without a pending last word");

  // once a tour has failed it stays failed until the result
  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_STEP2) && !feas_q) |=> !feas_q)
    else $error("infeasible tour became feasible again");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ret_q)
    else $error("depot return flag left set between tours");

endmodule
